@@ sv/onenc_pkg.sv @@
`default_nettype none

package onenc_pkg;

    // width of the packed result word, fixed whatever the code width
    localparam int PACKED_BITS = 32;

    typedef logic [PACKED_BITS-1:0] packed_code_t;

endpackage

`default_nettype wire

@@ sv/onenc_in_if.sv @@
`default_nettype none

interface onenc_in_if #(
    parameter int COMPONENT_BITS = 16
);
    logic                             valid;
    logic                             ready;
    logic signed [COMPONENT_BITS-1:0] normal_x;
    logic signed [COMPONENT_BITS-1:0] normal_y;
    logic signed [COMPONENT_BITS-1:0] normal_z;

    modport source (
        output valid,
        output normal_x,
        output normal_y,
        output normal_z,
        input  ready
    );

    modport sink (
        input  valid,
        input  normal_x,
        input  normal_y,
        input  normal_z,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/onenc_out_if.sv @@
`default_nettype none

interface onenc_out_if;
    import onenc_pkg::*;

    logic         valid;
    logic         ready;
    packed_code_t packed_code;
    logic         zero_vector;

    modport source (
        output valid,
        output packed_code,
        output zero_vector,
        input  ready
    );

    modport sink (
        input  valid,
        input  packed_code,
        input  zero_vector,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/onenc_front.sv @@
`default_nettype none

module onenc_front #(
    parameter int  COMPONENT_BITS = 16,
    parameter int  CODE_BITS      = 16,
    localparam int DW             = COMPONENT_BITS + 2
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [COMPONENT_BITS-1:0] in_x,
    input  wire logic [COMPONENT_BITS-1:0] in_y,
    input  wire logic [COMPONENT_BITS-1:0] in_z,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [DW-1:0]                  out_ru,
    output logic [CODE_BITS-1:0]           out_wu,
    output logic [DW-1:0]                  out_rv,
    output logic [CODE_BITS-1:0]           out_wv,
    output logic [DW-1:0]                  out_d,
    output logic                           out_zero
);
    localparam int CW = COMPONENT_BITS;
    localparam int SW = COMPONENT_BITS + 1;
    localparam int PW = DW + CODE_BITS;

    // stage 1: magnitudes, signs and l1 norm
    logic          s1_valid_reg;
    logic          x_neg_reg, y_neg_reg, z_neg_reg;
    logic [CW-1:0] ax_reg, ay_reg;
    logic [SW-1:0] s_reg;
    logic [CW-1:0] ax_next, ay_next, az_next;
    logic [SW-1:0] s_next;

    // stage 2: numerators over the denominator 2s
    logic          s2_valid_reg;
    logic          s2_ready;
    logic [DW-1:0] nu_reg, nv_reg, d2_reg;
    logic          zero2_reg;
    logic [DW-1:0] nu_next, nv_next, d_next;
    logic [DW-1:0] s_ext, ax_ext, ay_ext;
    logic          zero_next;

    // stage 3: dividend m*n split into high remainder and low bits
    logic                 s3_valid_reg;
    logic [DW-1:0]        ru_reg, rv_reg, d3_reg;
    logic [CODE_BITS-1:0] wu_reg, wv_reg;
    logic                 zero3_reg;
    logic [PW-1:0]        pu_next, pv_next;

    always_comb
    begin
        ax_next = in_x[CW-1] ? (~in_x + 1'b1) : in_x;
        ay_next = in_y[CW-1] ? (~in_y + 1'b1) : in_y;
        az_next = in_z[CW-1] ? (~in_z + 1'b1) : in_z;
        s_next  = SW'(ax_next) + SW'(ay_next) + SW'(az_next);
    end

    assign in_ready = !s1_valid_reg || s2_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            x_neg_reg <= in_x[CW-1];
            y_neg_reg <= in_y[CW-1];
            z_neg_reg <= in_z[CW-1];
            ax_reg    <= ax_next;
            ay_reg    <= ay_next;
            s_reg     <= s_next;
        end
    end

    always_comb
    begin
        s_ext     = DW'(s_reg);
        ax_ext    = DW'(ax_reg);
        ay_ext    = DW'(ay_reg);
        d_next    = {s_reg, 1'b0};
        zero_next = (s_reg == '0);
        if (!z_neg_reg)
        begin
            nu_next = x_neg_reg ? (s_ext - ax_ext) : (s_ext + ax_ext);
            nv_next = y_neg_reg ? (s_ext - ay_ext) : (s_ext + ay_ext);
        end
        else
        begin
            // fold the lower hemisphere outward, zero taken as positive
            nu_next = x_neg_reg ? ay_ext : (d_next - ay_ext);
            nv_next = y_neg_reg ? ax_ext : (d_next - ax_ext);
        end
        // zero vector: 1/2 of full scale gives the pole code
        if (zero_next)
        begin
            nu_next = DW'(1);
            nv_next = DW'(1);
            d_next  = DW'(2);
        end
    end

    assign s2_ready = !s2_valid_reg || out_ready || !s3_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            nu_reg    <= nu_next;
            nv_reg    <= nv_next;
            d2_reg    <= d_next;
            zero2_reg <= zero_next;
        end
    end

    // m*n with m = 2^code_bits - 1
    always_comb
    begin
        pu_next = {nu_reg, {CODE_BITS{1'b0}}} - PW'(nu_reg);
        pv_next = {nv_reg, {CODE_BITS{1'b0}}} - PW'(nv_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (!s3_valid_reg || out_ready)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((!s3_valid_reg || out_ready) && s2_valid_reg)
        begin
            ru_reg    <= pu_next[PW-1:CODE_BITS];
            wu_reg    <= pu_next[CODE_BITS-1:0];
            rv_reg    <= pv_next[PW-1:CODE_BITS];
            wv_reg    <= pv_next[CODE_BITS-1:0];
            d3_reg    <= d2_reg;
            zero3_reg <= zero2_reg;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_ru    = ru_reg;
    assign out_wu    = wu_reg;
    assign out_rv    = rv_reg;
    assign out_wv    = wv_reg;
    assign out_d     = d3_reg;
    assign out_zero  = zero3_reg;

`ifndef ASSERT_OFF
    a_num_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (nu_reg <= d2_reg) && (nv_reg <= d2_reg) && (d2_reg != '0))
        else $error("numerator above denominator");
`endif

endmodule

`default_nettype wire

@@ sv/onenc_div_stage.sv @@
`default_nettype none

module onenc_div_stage #(
    parameter int DW    = 18,
    parameter int CB    = 16,
    parameter int STEPS = 2
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [DW-1:0] in_ru,
    input  wire logic [CB-1:0] in_wu,
    input  wire logic [DW-1:0] in_rv,
    input  wire logic [CB-1:0] in_wv,
    input  wire logic [DW-1:0] in_d,
    input  wire logic          in_zero,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [DW-1:0]      out_ru,
    output logic [CB-1:0]      out_wu,
    output logic [DW-1:0]      out_rv,
    output logic [CB-1:0]      out_wv,
    output logic [DW-1:0]      out_d,
    output logic               out_zero
);
    logic          valid_reg;
    logic [DW-1:0] ru_reg, rv_reg, d_reg;
    logic [CB-1:0] wu_reg, wv_reg;
    logic          zero_reg;
    logic [DW-1:0] ru_next, rv_next;
    logic [CB-1:0] wu_next, wv_next;
    logic [DW:0]   trial_u, trial_v, d_ext;

    // restoring division: dividend bits leave the top of w, quotient bits enter below
    always_comb
    begin
        ru_next = in_ru;
        rv_next = in_rv;
        wu_next = in_wu;
        wv_next = in_wv;
        d_ext   = {1'b0, in_d};
        trial_u = '0;
        trial_v = '0;
        for (int k = 0; k < STEPS; k++)
        begin
            trial_u = {ru_next, wu_next[CB-1]};
            trial_v = {rv_next, wv_next[CB-1]};
            wu_next = {wu_next[CB-2:0], 1'b0};
            wv_next = {wv_next[CB-2:0], 1'b0};
            if (trial_u >= d_ext)
            begin
                ru_next    = DW'(trial_u - d_ext);
                wu_next[0] = 1'b1;
            end
            else
            begin
                ru_next = trial_u[DW-1:0];
            end
            if (trial_v >= d_ext)
            begin
                rv_next    = DW'(trial_v - d_ext);
                wv_next[0] = 1'b1;
            end
            else
            begin
                rv_next = trial_v[DW-1:0];
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            ru_reg   <= ru_next;
            rv_reg   <= rv_next;
            wu_reg   <= wu_next;
            wv_reg   <= wv_next;
            d_reg    <= in_d;
            zero_reg <= in_zero;
        end
    end

    assign out_valid = valid_reg;
    assign out_ru    = ru_reg;
    assign out_wu    = wu_reg;
    assign out_rv    = rv_reg;
    assign out_wv    = wv_reg;
    assign out_d     = d_reg;
    assign out_zero  = zero_reg;

`ifndef ASSERT_OFF
    a_rem_u_below_d: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ru_reg < d_reg)
        else $error("u remainder not below divisor");
`endif
`ifndef ASSERT_OFF
    a_rem_v_below_d: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> rv_reg < d_reg)
        else $error("v remainder not below divisor");
`endif

endmodule

`default_nettype wire

@@ sv/octahedral_normal_encoder.sv @@
// channel  | modport              | payload
// ---------+----------------------+--------------------------------------------
// normal   | onenc_in_if.sink     | normal_x, normal_y, normal_z (signed)
// code     | onenc_out_if.source  | packed_code (u high, v low), zero_vector
//
// one transfer per cycle in and out when neither side stalls
// three front stages, then one restoring division stage per two quotient bits,
// u and v divided side by side
// reset clears only the stage valid bits
// a stage holds its item while the next stage is full and stalled; empty stages
// still take items, so bubbles close up behind a stalled output
`default_nettype none

module octahedral_normal_encoder #(
    parameter int COMPONENT_BITS = 16,
    parameter int CODE_BITS      = 16
) (
    input wire logic     clk,
    input wire logic     rst_n,
    onenc_in_if.sink     normal,
    onenc_out_if.source  code
);
    import onenc_pkg::*;

    localparam int DW        = COMPONENT_BITS + 2;
    localparam int DIV_STEPS = 2;
    localparam int NST       = (CODE_BITS + DIV_STEPS - 1) / DIV_STEPS;

    logic                 vld  [0:NST];
    logic                 rdy  [0:NST];
    logic [DW-1:0]        ru   [0:NST];
    logic [DW-1:0]        rv   [0:NST];
    logic [CODE_BITS-1:0] wu   [0:NST];
    logic [CODE_BITS-1:0] wv   [0:NST];
    logic [DW-1:0]        dd   [0:NST];
    logic                 zero [0:NST];

    onenc_front #(
        .COMPONENT_BITS (COMPONENT_BITS),
        .CODE_BITS      (CODE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (normal.valid),
        .in_ready  (normal.ready),
        .in_x      ($unsigned(normal.normal_x)),
        .in_y      ($unsigned(normal.normal_y)),
        .in_z      ($unsigned(normal.normal_z)),
        .out_valid (vld[0]),
        .out_ready (rdy[0]),
        .out_ru    (ru[0]),
        .out_wu    (wu[0]),
        .out_rv    (rv[0]),
        .out_wv    (wv[0]),
        .out_d     (dd[0]),
        .out_zero  (zero[0])
    );

    for (genvar i = 0; i < NST; i++)
    begin : g_div
        onenc_div_stage #(
            .DW    (DW),
            .CB    (CODE_BITS),
            .STEPS (((CODE_BITS - i * DIV_STEPS) < DIV_STEPS) ?
                    (CODE_BITS - i * DIV_STEPS) : DIV_STEPS)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (vld[i]),
            .in_ready  (rdy[i]),
            .in_ru     (ru[i]),
            .in_wu     (wu[i]),
            .in_rv     (rv[i]),
            .in_wv     (wv[i]),
            .in_d      (dd[i]),
            .in_zero   (zero[i]),
            .out_valid (vld[i+1]),
            .out_ready (rdy[i+1]),
            .out_ru    (ru[i+1]),
            .out_wu    (wu[i+1]),
            .out_rv    (rv[i+1]),
            .out_wv    (wv[i+1]),
            .out_d     (dd[i+1]),
            .out_zero  (zero[i+1])
        );
    end

    logic unused_tail;
    assign unused_tail = ^{ru[NST], rv[NST], dd[NST]};

    assign rdy[NST]         = code.ready || unused_tail && 1'b0;
    assign code.valid       = vld[NST];
    assign code.packed_code = PACKED_BITS'({wu[NST], wv[NST]});
    assign code.zero_vector = zero[NST];

`ifndef ASSERT_OFF
    a_zero_gives_pole: assert property (@(posedge clk) disable iff (!rst_n)
        code.valid && code.zero_vector |-> code.packed_code ==
            PACKED_BITS'({1'b0, {(CODE_BITS-1){1'b1}}, 1'b0, {(CODE_BITS-1){1'b1}}}))
        else $error("zero vector without pole code");
`endif

endmodule

`default_nettype wire
